// ===== sv/btff_pkg.sv =====
// Shared constants and codes of the boundary-tag first-fit allocator.
package btff_pkg;
	localparam int TAG_W = 16;
	localparam int OFF_W = 12;
	localparam int BYTES_W = 13;
	localparam int STAT_W = 2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOFIT = 2'd2;
	localparam logic [STAT_W-1:0] ST_BADFREE = 2'd3;

	localparam int TAG_BYTES = 8;
	localparam int SPLIT_MIN = 16;
	localparam int HDR_BYTES = 4;
endpackage

// ===== sv/btff_tag_ram.sv =====
// Tag store: one write port, one registered read port.
module btff_tag_ram #(
	parameter int DEPTH = 2048,
	parameter int AW = 11
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [btff_pkg::TAG_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [btff_pkg::TAG_W-1:0] rdata
);
	import btff_pkg::*;

	logic [TAG_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/boundary_tag_first_fit_allocator_unit.sv =====
// Boundary-tag first-fit allocator: walk sequencer around a tag store.
// Allocate: a read and a check per block visited, then 2 or 4 tag writes on a fit.
// Free: read and check each block up to the target, 1 neighbor read, 2 tag writes.
// One item at a time; input stalls until its result has been taken.
// After reset the block stalls while it writes the two sentinels and the free block.
// The walk time is set by the single read port of the tag store.
module boundary_tag_first_fit_allocator_unit #(
	parameter int HEAP_BYTES = 4096,
	parameter int MIN_PAYLOAD_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [btff_pkg::OFF_W-1:0]    request_bytes,
	input  logic [btff_pkg::OFF_W-1:0]    block_offset,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [btff_pkg::OFF_W-1:0]    granted_offset,
	output logic [btff_pkg::BYTES_W-1:0]  granted_bytes,
	output logic [btff_pkg::STAT_W-1:0]   status
);
	import btff_pkg::*;

	localparam int WORDS = (HEAP_BYTES + 1) / 2;
	localparam int SPAN = 2 * WORDS;
	localparam int WW = $clog2(WORDS);
	localparam int BW = $clog2(SPAN) + 1;
	localparam int CW = (BW > 16) ? BW : 16;

	localparam logic [CW-1:0] SPAN_C = CW'(SPAN);
	localparam logic [CW-1:0] LAST_P = CW'(SPAN - HDR_BYTES);
	localparam logic [CW-1:0] HDR_C = CW'(HDR_BYTES);
	localparam logic [CW-1:0] TAG_C = CW'(TAG_BYTES);
	localparam logic [CW-1:0] SPLIT_C = CW'(SPLIT_MIN);
	localparam logic [CW-1:0] MIN_C = CW'(MIN_PAYLOAD_BYTES);

	localparam logic [3:0] S_INIT0 = 4'd0;
	localparam logic [3:0] S_INIT1 = 4'd1;
	localparam logic [3:0] S_IDLE = 4'd2;
	localparam logic [3:0] S_RD = 4'd3;
	localparam logic [3:0] S_CHK = 4'd4;
	localparam logic [3:0] S_NCHK = 4'd5;
	localparam logic [3:0] S_W0 = 4'd6;
	localparam logic [3:0] S_W1 = 4'd7;
	localparam logic [3:0] S_W2 = 4'd8;
	localparam logic [3:0] S_W3 = 4'd9;

	logic [3:0]          state_q;
	logic                op_q;
	logic                init_q;
	logic                split_q;
	logic                abit_q;
	logic                prev_free_q;
	logic [CW-1:0]       p_q, need_q, target_q, prev_p_q, prev_size_q, size_q;
	logic [CW-1:0]       st_q, tot_q, sp_q, rest_q;
	logic                out_valid_q;
	logic [OFF_W-1:0]    off_q;
	logic [BYTES_W-1:0]  bytes_q;
	logic [STAT_W-1:0]   stat_q;

	logic                we;
	logic [WW-1:0]       waddr, raddr;
	logic [TAG_W-1:0]    wdata, rdata;
	logic [CW-1:0]       wbyte, rbyte, size_c, req_c, min_c, rnd_c, nsize_c, tot_c, st_c;
	logic                accept;

	btff_tag_ram #(.DEPTH(WORDS), .AW(WW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || out_valid_q;
	assign size_c = {{(CW-16){1'b0}}, rdata[15:1], 1'b0};
	assign req_c = CW'(request_bytes);
	assign min_c = (req_c < MIN_C) ? MIN_C : req_c;
	assign rnd_c = (min_c + CW'(1)) & ~CW'(1);

	always_comb begin
		nsize_c = size_c;
		st_c = p_q;
		tot_c = size_q;
		if (prev_free_q) begin
			st_c = prev_p_q;
			tot_c = size_q + prev_size_q;
		end
		if (!rdata[0] && nsize_c != '0) begin
			tot_c = tot_c + nsize_c;
		end
	end

	always_comb begin
		we = 1'b0;
		wbyte = '0;
		wdata = '0;
		unique case (state_q)
			S_INIT0: begin
				we = 1'b1;
				wbyte = '0;
				wdata = TAG_W'(1);
			end
			S_INIT1: begin
				we = 1'b1;
				wbyte = LAST_P;
				wdata = TAG_W'(1);
			end
			S_W0: begin
				we = 1'b1;
				wbyte = st_q - HDR_C;
				wdata = TAG_W'(tot_q) | TAG_W'(abit_q);
			end
			S_W1: begin
				we = 1'b1;
				wbyte = st_q + tot_q - TAG_C;
				wdata = TAG_W'(tot_q) | TAG_W'(abit_q);
			end
			S_W2: begin
				we = 1'b1;
				wbyte = sp_q - HDR_C;
				wdata = TAG_W'(rest_q);
			end
			S_W3: begin
				we = 1'b1;
				wbyte = sp_q + rest_q - TAG_C;
				wdata = TAG_W'(rest_q);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end
	assign waddr = wbyte[WW:1];

	always_comb begin
		rbyte = p_q - HDR_C;
		if (state_q == S_CHK) begin
			rbyte = p_q + size_c - HDR_C;
		end
	end
	assign raddr = rbyte[WW:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT0;
			out_valid_q <= 1'b0;
			init_q <= 1'b1;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT0: state_q <= S_INIT1;
				S_INIT1: state_q <= S_W0;
				S_IDLE: begin
					if (accept) begin
						init_q <= 1'b0;
						if (opcode == OP_ALLOC && request_bytes == '0) begin
							out_valid_q <= 1'b1;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					if (p_q > LAST_P || (op_q == OP_FREE && p_q > target_q)) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (size_c == '0) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (op_q == OP_ALLOC) begin
						if (!rdata[0] && size_c >= need_q) begin
							state_q <= S_W0;
						end else begin
							state_q <= S_RD;
						end
					end else if (p_q == target_q) begin
						if (!rdata[0]) begin
							out_valid_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_NCHK;
						end
					end else begin
						state_q <= S_RD;
					end
				end
				S_NCHK: state_q <= S_W0;
				S_W0: state_q <= S_W1;
				S_W1: begin
					if (split_q) begin
						state_q <= S_W2;
					end else begin
						state_q <= S_IDLE;
						if (!init_q) begin
							out_valid_q <= 1'b1;
						end
					end
				end
				S_W2: state_q <= S_W3;
				S_W3: begin
					state_q <= S_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_INIT1: begin
				st_q <= CW'(8);
				tot_q <= SPAN_C - TAG_C;
				abit_q <= 1'b0;
				split_q <= 1'b0;
			end
			S_IDLE: begin
				if (accept) begin
					op_q <= opcode;
					p_q <= TAG_C;
					need_q <= rnd_c + TAG_C;
					target_q <= CW'(block_offset);
					prev_free_q <= 1'b0;
					prev_p_q <= '0;
					prev_size_q <= '0;
					off_q <= '0;
					bytes_q <= '0;
					if (opcode == OP_ALLOC) begin
						stat_q <= (request_bytes == '0) ? ST_ZERO : ST_NOFIT;
					end else begin
						stat_q <= ST_BADFREE;
					end
				end
			end
			S_CHK: begin
				size_q <= size_c;
				if (op_q == OP_ALLOC) begin
					if (!rdata[0] && size_c >= need_q) begin
						stat_q <= ST_OK;
						off_q <= p_q[OFF_W-1:0];
						st_q <= p_q;
						abit_q <= 1'b1;
						sp_q <= p_q + need_q;
						rest_q <= size_c - need_q;
						if (size_c - need_q >= SPLIT_C) begin
							split_q <= 1'b1;
							tot_q <= need_q;
							bytes_q <= need_q[BYTES_W-1:0];
						end else begin
							split_q <= 1'b0;
							tot_q <= size_c;
							bytes_q <= size_c[BYTES_W-1:0];
						end
					end else begin
						p_q <= p_q + size_c;
					end
				end else if (p_q != target_q) begin
					prev_p_q <= p_q;
					prev_size_q <= size_c;
					prev_free_q <= !rdata[0];
					p_q <= p_q + size_c;
				end
			end
			S_NCHK: begin
				stat_q <= ST_OK;
				st_q <= st_c;
				tot_q <= tot_c;
				abit_q <= 1'b0;
				split_q <= 1'b0;
			end
			default: begin
				p_q <= p_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign granted_offset = off_q;
	assign granted_bytes = bytes_q;
	assign status = stat_q;

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == S_IDLE && !out_valid_q)
		else $error("beat accepted while busy");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status != ST_OK |-> granted_bytes == '0 && granted_offset == '0)
		else $error("failed result carries a grant");
	a_grant_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status == ST_OK |-> granted_offset[0] == 1'b0 && granted_bytes[0] == 1'b0)
		else $error("odd grant");
	a_chk_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHK |-> $past(state_q) == S_RD)
		else $error("tag check without read");
endmodule

// ===== test/tb_boundary_tag_first_fit_allocator_unit.sv =====
// Self-checking testbench for the boundary-tag first-fit allocator: predicts every grant and free.
module tb_boundary_tag_first_fit_allocator_unit;
	import btff_pkg::*;

	localparam int HEAP = 4096;
	localparam int MINPAY = 8;
	localparam int WORDS = (HEAP + 1) / 2;
	localparam int SPAN = 2 * WORDS;

	typedef struct packed {
		logic [OFF_W-1:0] offset;
		logic [BYTES_W-1:0] bytes;
		logic [STAT_W-1:0] stat;
	} grant_t;

	class heap_scoreboard;
		logic [TAG_W-1:0] tags [WORDS];
		grant_t pending [$];
		int errors;

		function new();
			errors = 0;
			foreach (tags[i]) tags[i] = '0;
			put_tag(0, 1);
			put_tag(SPAN - 4, 1);
			mark(8, SPAN - 8, 1'b0);
		endfunction

		function int get_tag(int addr);
			if ((addr >> 1) >= WORDS) return 1;
			return int'(tags[addr >> 1]);
		endfunction

		function void put_tag(int addr, int value);
			int idx;
			idx = addr >> 1;
			if (idx < WORDS) tags[idx] = value[15:0];
			if (idx + 1 < WORDS) tags[idx + 1] = '0;
		endfunction

		function void mark(int payload, int size, logic used);
			int v;
			v = (size & ~1) | int'(used);
			put_tag(payload - HDR_BYTES, v);
			put_tag(payload + size - TAG_BYTES, v);
		endfunction

		function void note_request(logic op, logic [OFF_W-1:0] req, logic [OFF_W-1:0] target);
			grant_t g;
			int p, need, tag, size, rest, granted, prev_p, prev_size, ntag, nsize, start, total;
			bit prev_free, done;
			g = '{default: '0};
			p = 8;
			done = 0;
			if (op == OP_ALLOC) begin
				g.stat = ST_NOFIT;
				if (req == 0) begin
					g.stat = ST_ZERO;
				end else begin
					need = (req < MINPAY) ? MINPAY : int'(req);
					need = ((need + 1) & ~1) + TAG_BYTES;
					while (!done && p + 4 <= SPAN) begin
						tag = get_tag(p - 4);
						size = tag & ~1;
						if (size == 0) break;
						if (!tag[0] && size >= need) begin
							rest = size - need;
							granted = size;
							if (rest >= SPLIT_MIN) begin
								granted = need;
								mark(p + need, rest, 1'b0);
							end
							mark(p, granted, 1'b1);
							g.offset = OFF_W'(p);
							g.bytes = BYTES_W'(granted);
							g.stat = ST_OK;
							done = 1;
						end
						p += size;
					end
				end
			end else begin
				g.stat = ST_BADFREE;
				prev_free = 0;
				prev_p = 0;
				prev_size = 0;
				while (!done && p + 4 <= SPAN && p <= target) begin
					tag = get_tag(p - 4);
					size = tag & ~1;
					if (size == 0) break;
					if (p == target) begin
						if (!tag[0]) break;
						ntag = get_tag(p + size - 4);
						nsize = ntag & ~1;
						start = p;
						total = size;
						if (prev_free) begin
							start = prev_p;
							total += prev_size;
						end
						if (!ntag[0] && nsize != 0) total += nsize;
						mark(start, total, 1'b0);
						g.stat = ST_OK;
						done = 1;
					end else begin
						prev_p = p;
						prev_size = size;
						prev_free = !tag[0];
						p += size;
					end
				end
			end
			pending.push_back(g);
		endfunction

		function void check_result(grant_t got);
			grant_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.offset !== want.offset) begin
				$display("%0t: granted_offset expected %0d actual %0d", $time, want.offset,
					got.offset);
				errors++;
			end
			if (got.bytes !== want.bytes) begin
				$display("%0t: granted_bytes expected %0d actual %0d", $time, want.bytes,
					got.bytes);
				errors++;
			end
			if (got.stat !== want.stat) begin
				$display("%0t: status expected %0d actual %0d", $time, want.stat, got.stat);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, in_valid, in_stall, opcode, out_valid, out_stall;
	logic [OFF_W-1:0] request_bytes, block_offset, granted_offset;
	logic [BYTES_W-1:0] granted_bytes;
	logic [STAT_W-1:0] status;

	heap_scoreboard board;
	int live [$];
	bit calm;

	boundary_tag_first_fit_allocator_unit #(.HEAP_BYTES(HEAP), .MIN_PAYLOAD_BYTES(MINPAY)) u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .request_bytes(request_bytes), .block_offset(block_offset),
		.out_valid(out_valid), .out_stall(out_stall), .granted_offset(granted_offset),
		.granted_bytes(granted_bytes), .status(status)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("boundary_tag_first_fit_allocator_unit test failed");
		$finish;
	end

	// sometimes hold off the sender for a random burst, then send one beat
	task automatic send_beat(logic op, logic [OFF_W-1:0] req, logic [OFF_W-1:0] off);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		request_bytes <= req;
		block_offset <= off;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_request(op, req, off);
		if (op == OP_ALLOC && board.pending[$].stat == ST_OK)
			live.push_back(int'(board.pending[$].offset));
	endtask

	task automatic free_some();
		int k;
		logic [OFF_W-1:0] off;
		k = $urandom_range(0, live.size() - 1);
		off = OFF_W'(live[k]);
		live.delete(k);
		send_beat(OP_FREE, OFF_W'($urandom), off);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				board.check_result('{granted_offset, granted_bytes, status});
			if (!calm && $urandom_range(0, 7) == 0)
				out_stall <= 1'b1;
			else if (calm || $urandom_range(0, 2) == 0)
				out_stall <= 1'b0;
		end
	end

	initial begin
		int n, waited;
		board = new();
		calm = 0;
		arst_n = 0;
		in_valid = 0;
		opcode = OP_ALLOC;
		request_bytes = '0;
		block_offset = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		send_beat(OP_ALLOC, 0, 0);
		send_beat(OP_ALLOC, 1, 12'hfff);
		send_beat(OP_ALLOC, 7, 0);
		send_beat(OP_ALLOC, 9, 0);
		send_beat(OP_ALLOC, 12'hfff, 0);
		send_beat(OP_ALLOC, 100, 0);
		send_beat(OP_ALLOC, 2, 0);
		send_beat(OP_FREE, 0, 12'hfff);
		send_beat(OP_FREE, 0, 0);
		send_beat(OP_FREE, 0, 9);
		send_beat(OP_FREE, 0, 10);
		while (live.size() > 0) begin
			send_beat(OP_FREE, 0, OFF_W'(live[0]));
			live.pop_front();
		end
		send_beat(OP_FREE, 0, 8);
		send_beat(OP_ALLOC, 4080, 0);
		send_beat(OP_ALLOC, 4079, 0);
		send_beat(OP_FREE, 0, 8);
		send_beat(OP_ALLOC, 12'h555, 12'haaa);
		send_beat(OP_ALLOC, 12'haaa, 12'h555);
		for (n = 0; n < 1550; n++) begin
			if (n > 1400) calm = 1;
			case ($urandom_range(0, 19))
				0: send_beat(OP_FREE, OFF_W'($urandom), OFF_W'($urandom));
				1: send_beat(OP_ALLOC, OFF_W'($urandom), OFF_W'($urandom));
				2, 3, 4, 5, 6, 7, 8: begin
					if (live.size() > 0) free_some();
					else send_beat(OP_ALLOC, OFF_W'($urandom_range(1, 300)), OFF_W'($urandom));
				end
				default: send_beat(OP_ALLOC,
					OFF_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 20) :
						$urandom_range(1, 400)),
					OFF_W'($urandom));
			endcase
		end
		in_valid <= 1'b0;
		waited = 0;
		while (board.pending.size() > 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("boundary_tag_first_fit_allocator_unit test passed");
		else
			$display("boundary_tag_first_fit_allocator_unit test failed");
		$finish;
	end
endmodule

// ===== boundary_tag_first_fit_allocator_unit.f =====
sv/btff_pkg.sv
sv/btff_tag_ram.sv
sv/boundary_tag_first_fit_allocator_unit.sv
test/tb_boundary_tag_first_fit_allocator_unit.sv
